// File: rtl/drc_pkg.sv
// drc_pkg: shared types, constants and helpers for the dhcp request classifier
// no dependencies; imported by every module of the block but drc_queue
`default_nettype none

package drc_pkg;

	// default width of the per-packet byte counter
	localparam int unsigned COUNTER_BITS_DEF = 12;
	// width of the length bound registers
	localparam int unsigned CFG_W = 12;
	// depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// fixed offsets in the bootp payload
	localparam int unsigned OPT_START  = 240;
	localparam int unsigned COOKIE_POS = 236;
	localparam int unsigned HW_LEN_POS = 2;

	// field codes
	localparam logic [7:0] BOOT_REQUEST = 8'd1;
	localparam logic [7:0] TYPE_TAG     = 8'd53;
	localparam logic [7:0] PAD_TAG      = 8'h00;
	localparam logic [7:0] END_TAG      = 8'hFF;
	localparam logic [7:0] MSG_DISCOVER = 8'd1;
	localparam logic [7:0] MSG_REQUEST  = 8'd3;

	// register indexes on the config port
	localparam logic REG_MIN_LENGTH = 1'b0;
	localparam logic REG_MAX_LENGTH = 1'b1;

	// reset values of the length bounds
	localparam logic [CFG_W-1:0] MIN_LENGTH_RST = 12'd240;
	localparam logic [CFG_W-1:0] MAX_LENGTH_RST = 12'd576;

	typedef enum logic [1:0] {
		VERDICT_INVALID  = 2'd0,
		VERDICT_DISCOVER = 2'd1,
		VERDICT_REQUEST  = 2'd2,
		VERDICT_UNTYPED  = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		verdict_t   verdict;
		logic [7:0] chaddr_len;
	} out_beat_t;

	// per-byte classification handed from front to back
	typedef struct packed {
		logic last;
		logic examine;
		logic hdr_bad;
		logic cookie_bad;
		logic is_hw;
		logic len_ok;
	} byte_flags_t;

	// magic cookie 63 82 53 63
	function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h63;
			2'd1: b = 8'h82;
			2'd2: b = 8'h53;
			2'd3: b = 8'h63;
			default: b = 8'h63;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// File: rtl/drc_queue.sv
// drc_queue: short flop-based fifo between classifier front and back
// generic word width; no package dependencies
`default_nettype none

module drc_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_word,
	output logic                  pop_valid,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_word
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (fill_q != CNT_W'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_word   = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// storage, no reset needed on payload
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/drc_front.sv
// drc_front: accepts payload beats, tracks byte position and classifies each byte
// depends on drc_pkg
`default_nettype none

module drc_front #(
	parameter int unsigned COUNTER_BITS = drc_pkg::COUNTER_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire drc_pkg::in_beat_t            in_data,
	input  wire logic [drc_pkg::CFG_W-1:0]    min_length,
	input  wire logic [drc_pkg::CFG_W-1:0]    max_length,
	output logic                              push,
	input  wire logic                         push_ready,
	output drc_pkg::byte_flags_t              flags,
	output logic [7:0]                        data,
	output logic [COUNTER_BITS-1:0]           pos
);

	import drc_pkg::*;

	localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
	localparam int unsigned CMP_W = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;

	logic [COUNTER_BITS-1:0] count_q;
	logic                    examine;
	logic [COUNTER_BITS-1:0] len;
	logic [CMP_W-1:0]        len_w;
	logic                    in_cookie;

	assign in_ready = push_ready;
	assign push     = in_valid && push_ready;

	// position of this byte and packet length if it is the last one
	assign examine = (count_q != CNT_MAX);
	assign pos     = count_q;
	assign data    = in_data.data_byte;
	assign len     = examine ? count_q + 1'b1 : count_q;
	assign len_w   = CMP_W'(len);

	assign in_cookie = (pos >= COUNTER_BITS'(COOKIE_POS)) &&
	                   (pos < COUNTER_BITS'(OPT_START));

	// per-byte checks
	always_comb begin
		flags.last       = in_data.last_byte;
		flags.examine    = examine;
		flags.hdr_bad    = examine && (pos < COUNTER_BITS'(HW_LEN_POS)) &&
		                   (in_data.data_byte != BOOT_REQUEST);
		flags.cookie_bad = examine && in_cookie &&
		                   (in_data.data_byte != cookie_byte(pos[1:0]));
		flags.is_hw      = examine && (pos == COUNTER_BITS'(HW_LEN_POS));
		flags.len_ok     = (len_w >= CMP_W'(OPT_START)) &&
		                   (len_w >= CMP_W'(min_length)) &&
		                   (len_w <= CMP_W'(max_length));
	end

	// saturating byte counter, cleared after the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (in_data.last_byte) begin
				count_q <= '0;
			end else if (examine) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/drc_back.sv
// drc_back: option walker, header state and verdict output register
// depends on drc_pkg
`default_nettype none

module drc_back #(
	parameter int unsigned COUNTER_BITS = drc_pkg::COUNTER_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    pop_valid,
	output logic                         pop,
	input  wire drc_pkg::byte_flags_t    flags,
	input  wire logic [7:0]              data,
	input  wire logic [COUNTER_BITS-1:0] pos,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output drc_pkg::out_beat_t           out_data
);

	import drc_pkg::*;

	typedef enum logic [1:0] {
		FOUND_NONE     = 2'd0,
		FOUND_DISCOVER = 2'd1,
		FOUND_REQUEST  = 2'd2
	} found_t;

	localparam logic [COUNTER_BITS-1:0] CNT_MAX   = '1;
	localparam logic [COUNTER_BITS-1:0] START_POS = COUNTER_BITS'(OPT_START);

	logic                    header_ok_q, header_ok_n;
	logic                    cookie_ok_q, cookie_ok_n;
	logic [7:0]              hw_len_q, hw_len_n;
	logic [COUNTER_BITS-1:0] next_tag_q, next_tag_n;
	logic [7:0]              pend_tag_q, pend_tag_n;
	logic [7:0]              pend_len_q, pend_len_n;
	logic                    stopped_q, stopped_n;
	found_t                  found_q, found_n;
	logic                    out_valid_q;
	out_beat_t               out_data_q;

	logic                    fire;
	logic [COUNTER_BITS-1:0] offset;
	logic [COUNTER_BITS-1:0] pos_inc;
	logic [COUNTER_BITS:0]   jump;
	logic                    ok;

	// a last beat waits for the output register, other beats flow
	assign pop  = pop_valid && (!flags.last || !out_valid_q || out_ready);
	assign fire = pop;

	assign offset  = pos - next_tag_q;
	assign pos_inc = pos + 1'b1;
	assign jump    = {1'b0, next_tag_q} + (COUNTER_BITS + 1)'(pend_len_q) +
	                 (COUNTER_BITS + 1)'(2);

	// header fields and option walk for one byte
	always_comb begin
		header_ok_n = header_ok_q && !flags.hdr_bad;
		cookie_ok_n = cookie_ok_q && !flags.cookie_bad;
		hw_len_n    = flags.is_hw ? data : hw_len_q;
		next_tag_n  = next_tag_q;
		pend_tag_n  = pend_tag_q;
		pend_len_n  = pend_len_q;
		stopped_n   = stopped_q;
		found_n     = found_q;
		if (flags.examine && !stopped_q && (pos >= next_tag_q)) begin
			if (offset == '0) begin
				// tag byte
				if (data == END_TAG) begin
					stopped_n = 1'b1;
				end else if (data == PAD_TAG) begin
					next_tag_n = pos_inc;
					stopped_n  = (pos_inc == CNT_MAX);
				end else begin
					pend_tag_n = data;
				end
			end else if (offset == COUNTER_BITS'(1)) begin
				pend_len_n = data;
			end else if (offset == COUNTER_BITS'(2)) begin
				// first value byte
				if (pend_tag_q == TYPE_TAG && data == MSG_DISCOVER) begin
					found_n   = FOUND_DISCOVER;
					stopped_n = 1'b1;
				end else if (pend_tag_q == TYPE_TAG && data == MSG_REQUEST) begin
					found_n   = FOUND_REQUEST;
					stopped_n = 1'b1;
				end else if (jump >= {1'b0, CNT_MAX}) begin
					next_tag_n = CNT_MAX;
					stopped_n  = 1'b1;
				end else begin
					next_tag_n = jump[COUNTER_BITS-1:0];
				end
			end
		end
	end

	assign ok = header_ok_n && cookie_ok_n && flags.len_ok;

	// per-packet state, cleared after the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_ok_q <= 1'b1;
			cookie_ok_q <= 1'b1;
			hw_len_q    <= '0;
			next_tag_q  <= START_POS;
			pend_tag_q  <= '0;
			pend_len_q  <= '0;
			stopped_q   <= 1'b0;
			found_q     <= FOUND_NONE;
		end else if (fire) begin
			if (flags.last) begin
				header_ok_q <= 1'b1;
				cookie_ok_q <= 1'b1;
				hw_len_q    <= '0;
				next_tag_q  <= START_POS;
				pend_tag_q  <= '0;
				pend_len_q  <= '0;
				stopped_q   <= 1'b0;
				found_q     <= FOUND_NONE;
			end else begin
				header_ok_q <= header_ok_n;
				cookie_ok_q <= cookie_ok_n;
				hw_len_q    <= hw_len_n;
				next_tag_q  <= next_tag_n;
				pend_tag_q  <= pend_tag_n;
				pend_len_q  <= pend_len_n;
				stopped_q   <= stopped_n;
				found_q     <= found_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && flags.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && flags.last) begin
			out_data_q.chaddr_len <= ok ? hw_len_n : 8'd0;
			if (!ok) begin
				out_data_q.verdict <= VERDICT_INVALID;
			end else begin
				case (found_n)
					FOUND_DISCOVER: out_data_q.verdict <= VERDICT_DISCOVER;
					FOUND_REQUEST:  out_data_q.verdict <= VERDICT_REQUEST;
					default:        out_data_q.verdict <= VERDICT_UNTYPED;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// File: rtl/dhcp_request_classifier.sv
// dhcp_request_classifier: top level, config registers, front, queue and back
// depends on drc_pkg, drc_front, drc_queue, drc_back
//
//   channel   dir  handshake            content
//   in        in   in_valid/in_ready    one payload byte and last flag a beat
//   out       out  out_valid/out_ready  verdict and hw address length
//   apb       in   psel/penable/pready  min_length at 0x0, max_length at 0x4
//
// takes one byte a cycle while in_ready is high; the last byte's verdict passes the queue, then the result register
// the front counts and checks bytes, the back walks options from a two-beat queue
// in_ready falls only when the queue holds two beats, i.e. a result waits unread
// only a last byte waits for the result register; other bytes never stall the back
// reset sets the length bounds to 240 and 576 and clears all per-packet state
`default_nettype none

module dhcp_request_classifier #(
	parameter int unsigned COUNTER_BITS = drc_pkg::COUNTER_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire drc_pkg::in_beat_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output drc_pkg::out_beat_t      out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	import drc_pkg::*;

	localparam int unsigned Q_W = $bits(byte_flags_t) + 8 + COUNTER_BITS;

	logic [CFG_W-1:0]        min_length_q;
	logic [CFG_W-1:0]        max_length_q;
	logic                    reg_sel;
	logic                    push;
	logic                    push_ready;
	byte_flags_t             f_flags;
	logic [7:0]              f_data;
	logic [COUNTER_BITS-1:0] f_pos;
	logic [Q_W-1:0]          push_word;
	logic [Q_W-1:0]          pop_word;
	logic                    pop_valid;
	logic                    pop;
	byte_flags_t             b_flags;
	logic [7:0]              b_data;
	logic [COUNTER_BITS-1:0] b_pos;

	// config port
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_LENGTH_RST;
			max_length_q <= MAX_LENGTH_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (reg_sel == REG_MIN_LENGTH) begin
				min_length_q <= pwdata[CFG_W-1:0];
			end else begin
				max_length_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	assign prdata = (reg_sel == REG_MAX_LENGTH) ? 32'(max_length_q) : 32'(min_length_q);

	// front: byte position and checks
	drc_front #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.min_length (min_length_q),
		.max_length (max_length_q),
		.push       (push),
		.push_ready (push_ready),
		.flags      (f_flags),
		.data       (f_data),
		.pos        (f_pos)
	);

	assign push_word = {f_flags, f_data, f_pos};

	// queue between front and back
	drc_queue #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_word   (pop_word)
	);

	assign {b_flags, b_data, b_pos} = pop_word;

	// back: option walk and verdict
	drc_back #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.flags     (b_flags),
		.data      (b_data),
		.pos       (b_pos),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// File: rtl/drc_checker.sv
// drc_checker: port-level assertions for the dhcp request classifier
// depends on drc_pkg; bound to dhcp_request_classifier
`default_nettype none

module drc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire drc_pkg::in_beat_t  in_data,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire drc_pkg::out_beat_t out_data,
	input wire logic               psel,
	input wire logic               penable,
	input wire logic               pwrite,
	input wire logic [2:0]         paddr,
	input wire logic [31:0]        pwdata,
	input wire logic [31:0]        prdata,
	input wire logic               pready
);

	import drc_pkg::*;

	// a stalled payload beat holds at the input
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("payload beat changed while stalled");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// invalid packets never report an address length
	a_invalid_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.verdict == VERDICT_INVALID |-> out_data.chaddr_len == 8'd0)
		else $error("invalid verdict with nonzero chaddr_len");

	// a register write reads back next cycle at the same address
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready ##1 $stable(paddr) |->
		prdata == {20'd0, $past(pwdata[11:0])})
		else $error("config readback mismatch");

	// registers are twelve bits wide
	a_prdata_high: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:12] == 20'd0)
		else $error("prdata upper bits set");

endmodule

bind dhcp_request_classifier drc_checker u_drc_checker (.*);

`default_nettype wire
